>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is released.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/pmf_pkg.sv
// Package of the pattern mask filter: sizes, register indexes and the mask character.
`default_nettype none

package pmf_pkg;

	localparam int MAX_PATTERN_DEF = 16;
	localparam int PAT_BYTES       = 16;
	localparam int PAT_LEN_W       = 5;
	localparam int CFG_DATA_W      = 64;
	localparam int CFG_IDX_W       = 2;
	localparam int BYTE_W          = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 2'd2;

	localparam logic [BYTE_W-1:0] MASK_CHAR = 8'h2A;

endpackage

`default_nettype wire

>>> rtl/pattern_mask_filter.sv
// Pattern mask filter: replaces each leftmost, non-overlapping match in a byte stream with '*'.
//
// Input beats (s_axis_*) carry one text byte each, tlast marking the end of the stream.
// Output beats (m_axis_*) carry the filtered bytes in the same order; occurrences of the
// pattern are replaced by 0x2A. The user sets the pattern (up to sixteen bytes) and length
// on the cfg_* write channel only while the stream is idle; the block does not enforce it.
//
// Each input beat is registered and then handled by one pass of the window compare into the
// output register, so beats may follow back to back while the output is not stalled; a byte
// that leaves at once passes through the input register and then the output register before
// it is offered. The output lags the input by up to pattern length minus one bytes, held in
// the window. A beat with tlast or a length of zero with bytes still held empties the window,
// and a length shortened mid-stream drains it until fewer bytes than the length remain, at
// one byte per cycle while the output is not stalled; input is held off until the drain ends.
// Output tlast sits on the last drained byte of a tlast beat. A length of zero passes bytes.
//
// Reset clears the window, the pattern registers and both channels. When the receiver stalls,
// the output register holds its beat and beats that release no byte are still taken; the
// first beat that would release one waits in the input register and holds input off until
// the output moves again.
`default_nettype none

module pattern_mask_filter #(
	parameter int MAX_PATTERN = pmf_pkg::MAX_PATTERN_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [pmf_pkg::BYTE_W-1:0]      s_axis_tdata,  // [7:0] in_byte
	input  wire logic                            s_axis_tlast,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic [pmf_pkg::BYTE_W-1:0]           m_axis_tdata,  // [7:0] out_byte
	output logic                                 m_axis_tlast,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [pmf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [pmf_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import pmf_pkg::*;

	localparam int CNT_W = $clog2(MAX_PATTERN + 1);
	localparam int CMP_W = (CNT_W > PAT_LEN_W) ? CNT_W : PAT_LEN_W;
	localparam int PV_W  = 8 * ((MAX_PATTERN > PAT_BYTES) ? MAX_PATTERN : PAT_BYTES);

	// configuration registers
	logic [CFG_DATA_W-1:0] pat_low_q, pat_high_q;
	logic [PAT_LEN_W-1:0]  pat_len_q;

	// input register
	logic              pend_valid_q, pend_last_q, pend_pushed_q;
	logic [BYTE_W-1:0] pend_byte_q;

	// window state
	logic [BYTE_W-1:0] win_q [MAX_PATTERN];
	logic [CNT_W-1:0]  fill_q, skip_q;

	// output register
	logic              out_valid_q, out_last_q;
	logic [BYTE_W-1:0] out_byte_q;

	logic [PV_W-1:0]   pat_vec;
	logic [BYTE_W-1:0] pat [MAX_PATTERN];
	logic [CMP_W-1:0]  len_wide;
	logic [CNT_W-1:0]  len_eff, fill_a, fill_n, skip_n;
	logic [BYTE_W-1:0] win_a [MAX_PATTERN];
	logic [BYTE_W-1:0] win_n [MAX_PATTERN];
	logic [BYTE_W-1:0] emit_byte;
	logic              len_zero, do_push, full, match, mask, pop, emit, done, clear;
	logic              out_free, go, in_take;

	always_comb begin
		pat_vec  = PV_W'({pat_high_q, pat_low_q});
		len_wide = CMP_W'(pat_len_q);
		len_eff  = (len_wide > CMP_W'(MAX_PATTERN)) ? CNT_W'(MAX_PATTERN) : CNT_W'(len_wide);
		len_zero = (len_eff == '0);
		do_push  = pend_valid_q && !pend_pushed_q && !len_zero;

		for (int k = 0; k < MAX_PATTERN; k++) begin
			pat[k]   = pat_vec[8*k +: 8];
			win_a[k] = (do_push && fill_q == CNT_W'(k)) ? pend_byte_q : win_q[k];
		end
		fill_a = fill_q + CNT_W'(do_push);

		match = 1'b1;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			if (CNT_W'(k) < len_eff && win_a[k] != pat[k]) begin
				match = 1'b0;
			end
		end

		full = !len_zero && (fill_a >= len_eff);
		mask = full && (skip_q == '0) && match;

		// With a zero length the held bytes drain first and the new byte then passes.
		if (len_zero) begin
			pop = (fill_q != '0);
		end else begin
			pop = full || (pend_last_q && fill_a != '0);
		end
		emit      = pend_valid_q && (pop || len_zero);
		emit_byte = pop ? (mask ? MASK_CHAR : win_a[0]) : pend_byte_q;
		fill_n    = pop ? fill_a - CNT_W'(1) : fill_a;

		if (len_zero) begin
			done = !pop;
		end else begin
			done = (fill_n < len_eff) && (!pend_last_q || fill_n == '0);
		end
		clear = done && (pend_last_q || len_zero);

		// The masked bytes behind the oldest one stay in the window as asterisks.
		for (int k = 0; k < MAX_PATTERN - 1; k++) begin
			win_n[k] = (mask && CNT_W'(k + 1) < len_eff) ? MASK_CHAR : win_a[k + 1];
		end
		win_n[MAX_PATTERN-1] = win_a[MAX_PATTERN-1];

		if (clear) begin
			skip_n = '0;
		end else if (mask) begin
			skip_n = len_eff - CNT_W'(1);
		end else if (pop && skip_q != '0) begin
			skip_n = skip_q - CNT_W'(1);
		end else begin
			skip_n = skip_q;
		end

		out_free      = !out_valid_q || m_axis_tready;
		go            = pend_valid_q && (!emit || out_free);
		s_axis_tready = !pend_valid_q || (go && done);
		in_take       = s_axis_tvalid && s_axis_tready;
	end

	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			pat_len_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PAT_LOW:  pat_low_q  <= cfg_data;
				CFG_PAT_HIGH: pat_high_q <= cfg_data;
				CFG_PAT_LEN:  pat_len_q  <= cfg_data[PAT_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q  <= 1'b0;
			pend_pushed_q <= 1'b0;
			fill_q        <= '0;
			skip_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (in_take) begin
				pend_valid_q  <= 1'b1;
				pend_pushed_q <= 1'b0;
			end else if (go) begin
				pend_valid_q  <= !done;
				pend_pushed_q <= 1'b1;
			end
			if (go) begin
				fill_q <= clear ? '0 : fill_n;
				skip_q <= skip_n;
			end
			if (out_free) begin
				out_valid_q <= go && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			pend_byte_q <= s_axis_tdata;
			pend_last_q <= s_axis_tlast;
		end
		if (go) begin
			for (int k = 0; k < MAX_PATTERN; k++) begin
				win_q[k] <= pop ? win_n[k] : win_a[k];
			end
		end
		if (go && emit) begin
			out_byte_q <= emit_byte;
			out_last_q <= pend_last_q && done;
		end
	end

endmodule

`default_nettype wire

>>> rtl/pmf_checker.sv
// Port checker of the pattern mask filter and its binding to the top level.
`default_nettype none

`include "assert_macros.svh"

module pmf_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_axis_tvalid,
	input wire logic       s_axis_tready,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata,
	input wire logic       m_axis_tlast
);

	// A stalled output beat stays offered.
	`CHK_ASSERT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output beat withdrawn while stalled")

	// A stalled output beat keeps its byte and its last flag.
	`CHK_ASSERT(a_out_stable, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast), "output beat changed while stalled")

	// With the output empty, a held-off input always makes progress in the next cycle.
	`CHK_ASSERT(a_no_deadlock, clk, arst_n, !s_axis_tready && !m_axis_tvalid |=> m_axis_tvalid || s_axis_tready, "filter stuck with empty output")

	// Leaving reset, nothing is offered and input is open.
	`CHK_ASSERT_ALWAYS(a_reset_clean, clk, $rose(arst_n) |-> !m_axis_tvalid && s_axis_tready, "filter not clean after reset")

endmodule

bind pattern_mask_filter pmf_checker u_pmf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
